// File: rtl/core/jptb_pkg.sv
package jptb_pkg;

    localparam int SYM_W  = 8;
    localparam int NODE_W = 10;
    localparam int LEN_W  = 11;
    localparam int POS_W  = 11;
    localparam int STR_W  = 16;
    localparam int ERR_W  = 2;

    localparam int MAX_LEN   = 1024;
    localparam int MAX_NODES = 1024;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TEXT_FULL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NODE_FULL = 2'd2;

    localparam logic [NODE_W-1:0] ODD_ROOT  = NODE_W'(0);
    localparam logic [NODE_W-1:0] EVEN_ROOT = NODE_W'(1);
    localparam logic [NODE_W-1:0] NO_NODE   = NODE_W'(0);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_WALK_C,
        ST_FIND_FC,
        ST_FIND_CHK,
        ST_FIND_RD,
        ST_CREATE,
        ST_CREATE2,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

// File: rtl/core/jptb_front.sv
module jptb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  jptb_pkg::t_item i_item,
    output logic          o_avail,
    output jptb_pkg::t_item o_item,
    input  logic          i_pop
);
    import jptb_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: rtl/core/jptb_back.sv
module jptb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  jptb_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_new,
    output logic [jptb_pkg::LEN_W-1:0]    o_suffix_len,
    output logic [jptb_pkg::NODE_W-1:0]   o_node_id,
    output logic [jptb_pkg::NODE_W-1:0]   o_pal_start,
    output logic [jptb_pkg::NODE_W-1:0]   o_distinct_count,
    output logic [jptb_pkg::STR_W-1:0]    o_string_index,
    output logic [jptb_pkg::ERR_W-1:0]    o_error
);
    import jptb_pkg::*;

    logic [SYM_W-1:0]  text_mem [MAX_LEN];
    logic [LEN_W-1:0]  len_mem  [MAX_NODES];
    logic [NODE_W-1:0] link_mem [MAX_NODES];
    logic [SYM_W-1:0]  sym_mem  [MAX_NODES];
    logic [NODE_W-1:0] sib_mem  [MAX_NODES];
    logic [NODE_W-1:0] fc_mem   [MAX_NODES];

    logic [SYM_W-1:0]  r_text_q, r_sym_q;
    logic [LEN_W-1:0]  r_len_q;
    logic [NODE_W-1:0] r_link_q, r_sib_q, r_fc_q;

    t_state r_state, n_state;

    logic [SYM_W-1:0]  r_sym, n_sym;
    logic              r_last, n_last;
    logic [NODE_W-1:0] r_node, n_node;
    logic [NODE_W-1:0] r_link, n_link;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [NODE_W-1:0] r_k, n_k;
    logic [NODE_W-1:0] r_head, n_head;
    logic [NODE_W-1:0] r_head1, n_head1;
    logic [NODE_W-1:0] r_parent, n_parent;
    logic [LEN_W-1:0]  r_nl, n_nl;
    logic [NODE_W-1:0] r_lk, n_lk;
    logic              r_phase2, n_phase2;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [NODE_W-1:0] r_count, n_count;
    logic [STR_W-1:0]  r_strings, n_strings;
    logic              r_is_new, n_is_new;
    logic [NODE_W-1:0] r_start, n_start;
    logic [ERR_W-1:0]  r_err, n_err;
    logic [NODE_W-1:0] r_fc0, n_fc0, r_fc1, n_fc1;

    logic              r_ovalid, n_ovalid;
    logic              r_o_is_new, n_o_is_new;
    logic [LEN_W-1:0]  r_o_slen, n_o_slen;
    logic [NODE_W-1:0] r_o_node, n_o_node;
    logic [NODE_W-1:0] r_o_start, n_o_start;
    logic [NODE_W-1:0] r_o_count, n_o_count;
    logic [STR_W-1:0]  r_o_str, n_o_str;
    logic [ERR_W-1:0]  r_o_err, n_o_err;

    logic              w_is_root;
    logic [LEN_W-1:0]  w_len_val;
    logic [NODE_W-1:0] w_link_val;
    logic [LEN_W:0]    w_idx;
    logic [NODE_W-1:0] w_tidx;
    logic              w_out_free;
    logic              w_node_full;
    logic [NODE_W-1:0] w_new_id;
    logic [NODE_W-1:0] w_first;
    logic [LEN_W-1:0]  w_nl;
    logic              w_text_we;
    logic              w_node_we;
    logic              w_fc_we;
    logic [NODE_W-1:0] w_fc_addr;
    logic [NODE_W-1:0] w_fc_data;

    assign w_is_root  = (r_node == ODD_ROOT) || (r_node == EVEN_ROOT);
    assign w_len_val  = w_is_root ? '0 : r_len_q;
    assign w_link_val = w_is_root ? ODD_ROOT : r_link_q;
    assign w_idx      = {1'b0, r_pos} - {1'b0, w_len_val} - (LEN_W+1)'(1);
    assign w_tidx     = w_idx[NODE_W-1:0];
    assign w_out_free = !r_ovalid || i_ready;
    assign w_node_full = ({1'b0, r_count} + (NODE_W+1)'(2)) >= (NODE_W+1)'(MAX_NODES);
    assign w_new_id   = r_count + NODE_W'(2);
    assign w_first    = (r_node == ODD_ROOT)  ? r_fc0 :
                        (r_node == EVEN_ROOT) ? r_fc1 : r_fc_q;
    assign w_nl       = (r_node == ODD_ROOT) ? LEN_W'(1) : r_len + LEN_W'(2);

    assign w_text_we = ((r_state == ST_FIND_RD) && !r_phase2 && (r_sym_q == r_sym))
                       || (r_state == ST_CREATE);
    assign w_node_we = (r_state == ST_CREATE);
    assign w_fc_we   = (r_state == ST_CREATE) ||
                       ((r_state == ST_CREATE2) && (r_parent != ODD_ROOT)
                        && (r_parent != EVEN_ROOT));
    assign w_fc_addr = (r_state == ST_CREATE) ? w_new_id : r_parent;
    assign w_fc_data = (r_state == ST_CREATE) ? NO_NODE : r_cur;

    always_ff @(posedge i_clk) begin
        if (w_text_we) begin
            text_mem[r_pos[NODE_W-1:0]] <= r_sym;
        end
        r_text_q <= text_mem[w_tidx];
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            len_mem[w_new_id]  <= r_nl;
            link_mem[w_new_id] <= r_lk;
            sym_mem[w_new_id]  <= r_sym;
            sib_mem[w_new_id]  <= r_head1;
        end
        r_len_q  <= len_mem[r_node];
        r_link_q <= link_mem[r_node];
        r_sym_q  <= sym_mem[r_k];
        r_sib_q  <= sib_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (w_fc_we) begin
            fc_mem[w_fc_addr] <= w_fc_data;
        end
        r_fc_q <= fc_mem[r_node];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail) n_state = r_pos[POS_W-1] ? ST_FIN : ST_WALK_A;
            end
            ST_WALK_A:   n_state = (r_node == ODD_ROOT) ? ST_FIND_FC : ST_WALK_B;
            ST_WALK_B:   n_state = w_idx[LEN_W] ? ST_WALK_A : ST_WALK_C;
            ST_WALK_C:   n_state = (r_text_q == r_sym) ? ST_FIND_FC : ST_WALK_A;
            ST_FIND_FC:  n_state = ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (r_k != NO_NODE) begin
                    n_state = ST_FIND_RD;
                end else if (r_phase2) begin
                    n_state = ST_CREATE;
                end else if (w_node_full) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = (w_nl == LEN_W'(1)) ? ST_CREATE : ST_WALK_A;
                end
            end
            ST_FIND_RD: begin
                if (r_sym_q != r_sym) n_state = ST_FIND_CHK;
                else n_state = r_phase2 ? ST_CREATE : ST_FIN;
            end
            ST_CREATE:   n_state = ST_CREATE2;
            ST_CREATE2:  n_state = ST_FIN;
            ST_FIN:      n_state = ST_OUT;
            ST_OUT:      n_state = w_out_free ? ST_IDLE : ST_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        n_sym      = r_sym;
        n_last     = r_last;
        n_node     = r_node;
        n_link     = r_link;
        n_len      = r_len;
        n_k        = r_k;
        n_head     = r_head;
        n_head1    = r_head1;
        n_parent   = r_parent;
        n_nl       = r_nl;
        n_lk       = r_lk;
        n_phase2   = r_phase2;
        n_cur      = r_cur;
        n_pos      = r_pos;
        n_count    = r_count;
        n_strings  = r_strings;
        n_is_new   = r_is_new;
        n_start    = r_start;
        n_err      = r_err;
        n_fc0      = r_fc0;
        n_fc1      = r_fc1;
        n_ovalid   = r_ovalid && !i_ready;
        n_o_is_new = r_o_is_new;
        n_o_slen   = r_o_slen;
        n_o_node   = r_o_node;
        n_o_start  = r_o_start;
        n_o_count  = r_o_count;
        n_o_str    = r_o_str;
        n_o_err    = r_o_err;
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    o_pop    = 1'b1;
                    n_sym    = i_item.symbol;
                    n_last   = i_item.last;
                    n_is_new = 1'b0;
                    n_start  = '0;
                    n_phase2 = 1'b0;
                    n_node   = r_cur;
                    n_err    = r_pos[POS_W-1] ? ERR_TEXT_FULL : ERR_NONE;
                end
            end
            ST_WALK_A: ;
            ST_WALK_B: begin
                n_link = w_link_val;
                n_len  = w_len_val;
                if (w_idx[LEN_W]) n_node = w_link_val;
            end
            ST_WALK_C: begin
                if (r_text_q != r_sym) n_node = r_link;
            end
            ST_FIND_FC: begin
                n_k    = w_first;
                n_head = w_first;
            end
            ST_FIND_CHK: begin
                if (r_k == NO_NODE) begin
                    if (r_phase2) begin
                        n_lk = EVEN_ROOT;
                    end else if (w_node_full) begin
                        n_err  = ERR_NODE_FULL;
                        n_node = r_cur;
                    end else begin
                        n_parent = r_node;
                        n_head1  = r_head;
                        n_nl     = w_nl;
                        if (w_nl == LEN_W'(1)) begin
                            n_lk = EVEN_ROOT;
                        end else begin
                            n_phase2 = 1'b1;
                            n_node   = r_link;
                        end
                    end
                end
            end
            ST_FIND_RD: begin
                if (r_sym_q != r_sym) begin
                    n_k = r_sib_q;
                end else if (r_phase2) begin
                    n_lk = r_k;
                end else begin
                    n_cur  = r_k;
                    n_node = r_k;
                    n_pos  = r_pos + POS_W'(1);
                end
            end
            ST_CREATE: begin
                n_start  = r_pos[NODE_W-1:0] + NODE_W'(1) - r_nl[NODE_W-1:0];
                n_pos    = r_pos + POS_W'(1);
                n_cur    = w_new_id;
                n_node   = w_new_id;
                n_count  = r_count + NODE_W'(1);
                n_is_new = 1'b1;
            end
            ST_CREATE2: begin
                if (r_parent == ODD_ROOT) n_fc0 = r_cur;
                if (r_parent == EVEN_ROOT) n_fc1 = r_cur;
            end
            ST_FIN: ;
            ST_OUT: begin
                if (w_out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_is_new = r_is_new;
                    n_o_slen   = w_is_root ? '0 : r_len_q;
                    n_o_node   = r_cur;
                    n_o_start  = r_start;
                    n_o_count  = r_count;
                    n_o_str    = r_strings;
                    n_o_err    = r_err;
                    if (r_last) begin
                        n_cur = EVEN_ROOT;
                        n_pos = '0;
                        if (r_strings != '1) n_strings = r_strings + STR_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cur     <= EVEN_ROOT;
            r_pos     <= '0;
            r_count   <= '0;
            r_strings <= '0;
            r_fc0     <= NO_NODE;
            r_fc1     <= NO_NODE;
            r_ovalid  <= 1'b0;
            r_phase2  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_strings <= n_strings;
            r_fc0     <= n_fc0;
            r_fc1     <= n_fc1;
            r_ovalid  <= n_ovalid;
            r_phase2  <= n_phase2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_last     <= n_last;
        r_node     <= n_node;
        r_link     <= n_link;
        r_len      <= n_len;
        r_k        <= n_k;
        r_head     <= n_head;
        r_head1    <= n_head1;
        r_parent   <= n_parent;
        r_nl       <= n_nl;
        r_lk       <= n_lk;
        r_is_new   <= n_is_new;
        r_start    <= n_start;
        r_err      <= n_err;
        r_o_is_new <= n_o_is_new;
        r_o_slen   <= n_o_slen;
        r_o_node   <= n_o_node;
        r_o_start  <= n_o_start;
        r_o_count  <= n_o_count;
        r_o_str    <= n_o_str;
        r_o_err    <= n_o_err;
    end

    assign o_valid          = r_ovalid;
    assign o_is_new         = r_o_is_new;
    assign o_suffix_len     = r_o_slen;
    assign o_node_id        = r_o_node;
    assign o_pal_start      = r_o_start;
    assign o_distinct_count = r_o_count;
    assign o_string_index   = r_o_str;
    assign o_error          = r_o_err;

endmodule

// File: rtl/core/joint_palindromic_tree_builder.sv
// Joint palindromic tree builder.
// Input channel: i_in_valid / o_in_ready carry one character item (i_symbol)
// with i_last marking the end of the current string. Output channel:
// o_out_valid / i_out_ready carry exactly one result item per input item.
// Items enter a two-entry queue; a sequencer then extends the longest suffix
// palindrome and looks up or creates the child node, one item at a time.
// Per item the sequencer takes it from the queue, walks the suffix links
// (a node is passed over without a text read when the compared position lies
// before the string start, and the odd root ends the walk), fetches the child
// list head, reads child entries until a match or the end of the list, then
// posts the result. A new node is written in two steps and, above length 1,
// needs a second walk and child search to find its suffix link. A character
// dropped for a full string buffer goes straight to posting its result.
// A finished result waits in the output register while the next item is
// processed; while i_out_ready is low the sequencer holds its result and the
// queue fills, after which o_in_ready drops.
// Reset (i_rst_n low, synchronous) empties the tree down to its two roots,
// sets the suffix to the even root, position, node and string counts to 0.
// No clearing pass is needed after reset.
module joint_palindromic_tree_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [jptb_pkg::SYM_W-1:0]    i_symbol,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_is_new,
    output logic [jptb_pkg::LEN_W-1:0]    o_suffix_len,
    output logic [jptb_pkg::NODE_W-1:0]   o_node_id,
    output logic [jptb_pkg::NODE_W-1:0]   o_pal_start,
    output logic [jptb_pkg::NODE_W-1:0]   o_distinct_count,
    output logic [jptb_pkg::STR_W-1:0]    o_string_index,
    output logic [jptb_pkg::ERR_W-1:0]    o_error
);
    import jptb_pkg::*;

    t_item w_in_item, w_q_item;
    logic  w_avail, w_pop;

    assign w_in_item.symbol = i_symbol;
    assign w_in_item.last   = i_last;

    jptb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_in_item),
        .o_avail (w_avail),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    jptb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_avail          (w_avail),
        .i_item           (w_q_item),
        .o_pop            (w_pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_is_new         (o_is_new),
        .o_suffix_len     (o_suffix_len),
        .o_node_id        (o_node_id),
        .o_pal_start      (o_pal_start),
        .o_distinct_count (o_distinct_count),
        .o_string_index   (o_string_index),
        .o_error          (o_error)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import jptb_pkg::*;

    localparam int NUM_RANDOM = 800;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [SYM_W-1:0]  i_symbol;
    logic              i_last;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_is_new;
    logic [LEN_W-1:0]  o_suffix_len;
    logic [NODE_W-1:0] o_node_id;
    logic [NODE_W-1:0] o_pal_start;
    logic [NODE_W-1:0] o_distinct_count;
    logic [STR_W-1:0]  o_string_index;
    logic [ERR_W-1:0]  o_error;

    joint_palindromic_tree_builder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_symbol(i_symbol), .i_last(i_last),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_is_new(o_is_new), .o_suffix_len(o_suffix_len), .o_node_id(o_node_id),
        .o_pal_start(o_pal_start), .o_distinct_count(o_distinct_count),
        .o_string_index(o_string_index), .o_error(o_error)
    );

    typedef struct packed {
        logic              is_new;
        logic [LEN_W-1:0]  suffix_len;
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] pal_start;
        logic [NODE_W-1:0] distinct_count;
        logic [STR_W-1:0]  string_index;
        logic [ERR_W-1:0]  error;
    } t_pal_result;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
        bit               has_fixed;
        t_pal_result      fixed;
    } t_stim_row;

    // tree model
    logic [SYM_W-1:0]  m_text [MAX_LEN];
    int                m_len  [MAX_NODES];
    int                m_link [MAX_NODES];
    bit                m_edge_ok [MAX_NODES];
    int                m_edge_par [MAX_NODES];
    logic [SYM_W-1:0]  m_edge_sym [MAX_NODES];
    int                m_suffix, m_pos, m_nodes, m_strings;

    t_pal_result expected_q[$];
    int  fail_cnt = 0;
    int  chars_sent = 0;
    int  send_idle_pct = 21, recv_idle_pct = 60;
    bit  recv_hold = 0;

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void tree_reset();
        for (int k = 0; k < MAX_NODES; k++) begin
            m_edge_ok[k] = 0;
            m_len[k] = 0;
            m_link[k] = 0;
        end
        m_len[0] = -1;
        m_suffix = 1;
        m_pos = 0;
        m_nodes = 0;
        m_strings = 0;
    endfunction

    function automatic bit mismatch_before(int node, logic [SYM_W-1:0] c);
        int idx;
        idx = m_pos - m_len[node] - 1;
        if (idx < 0 || idx >= MAX_LEN) return 1;
        return m_text[idx] != c;
    endfunction

    function automatic int walk_suffix(int node, logic [SYM_W-1:0] c);
        while (node != 0 && mismatch_before(node, c)) node = m_link[node];
        return node;
    endfunction

    function automatic int child_of(int parent, logic [SYM_W-1:0] c);
        for (int k = 0; k < m_nodes; k++)
            if (m_edge_ok[k] && m_edge_par[k] == parent && m_edge_sym[k] == c)
                return k + 2;
        return -1;
    endfunction

    function automatic t_pal_result extend_tree(logic [SYM_W-1:0] c, logic last);
        t_pal_result r;
        int cur, ch, id, nl, lk;
        r = '0;
        r.string_index = STR_W'(m_strings);
        r.error = ERR_NONE;
        if (m_pos >= MAX_LEN) begin
            r.error = ERR_TEXT_FULL;
        end else begin
            cur = walk_suffix(m_suffix, c);
            ch = child_of(cur, c);
            if (ch >= 0) begin
                m_suffix = ch;
                m_text[m_pos] = c;
                m_pos++;
            end else if (m_nodes + 2 >= MAX_NODES) begin
                r.error = ERR_NODE_FULL;
            end else begin
                id = m_nodes + 2;
                nl = m_len[cur] + 2;
                lk = 1;
                if (nl != 1) begin
                    lk = child_of(walk_suffix(m_link[cur], c), c);
                    if (lk < 0) lk = 1;
                end
                m_len[id] = nl;
                m_link[id] = lk;
                m_edge_ok[m_nodes] = 1;
                m_edge_par[m_nodes] = cur;
                m_edge_sym[m_nodes] = c;
                m_nodes++;
                r.pal_start = NODE_W'(m_pos + 1 - nl);
                m_text[m_pos] = c;
                m_pos++;
                m_suffix = id;
                r.is_new = 1;
            end
        end
        r.suffix_len = LEN_W'(m_len[m_suffix] < 0 ? 0 : m_len[m_suffix]);
        r.node_id = NODE_W'(m_suffix);
        r.distinct_count = NODE_W'(m_nodes);
        if (last) begin
            m_suffix = 1;
            m_pos = 0;
            if (m_strings < 65535) m_strings++;
        end
        return r;
    endfunction

    task automatic send_char(logic [SYM_W-1:0] c, logic last, bit gaps);
        if (gaps) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 0;
                @(negedge i_clk);
            end
        end
        i_symbol <= c;
        i_last <= last;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q.push_back(extend_tree(c, last));
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_row(t_stim_row row);
        t_pal_result r;
        send_char(row.symbol, row.last, 1);
        r = expected_q[$];
        if (row.has_fixed && r !== row.fixed) begin
            $display("%0t table row mismatch: expected %h predictor %h", $time, row.fixed, r);
            fail_cnt++;
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    // random string: mostly palindromes over a small alphabet, plus noise
    task automatic send_random_string(int n);
        logic [SYM_W-1:0] s [$];
        int len, alpha, kind;
        kind = $urandom_range(9);
        len = (kind == 0) ? $urandom_range(40, 120) : $urandom_range(1, 14);
        alpha = (kind < 7) ? $urandom_range(1, 3) : 256;
        for (int k = 0; k < len; k++) s.push_back(SYM_W'($urandom_range(alpha - 1)));
        if (kind < 5)
            for (int k = len - 1 - $urandom_range(1); k >= 0; k--) s.push_back(s[k]);
        if (alpha < 256)
            for (int k = 0; k < s.size(); k++) s[k] = s[k] ^ SYM_W'(n * 37);
        for (int k = 0; k < s.size(); k++) send_char(s[k], k == s.size() - 1, 1);
    endtask

    always @(posedge i_clk) begin
        t_pal_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_is_new, o_suffix_len, o_node_id, o_pal_start,
                    o_distinct_count, o_string_index, o_error};
            if (expected_q.size() == 0) begin
                $display("%0t unexpected item: actual %p", $time, got);
                fail_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    fail_cnt++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (recv_hold) i_out_ready <= 0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        t_stim_row rows [$];
        t_stim_row row;
        int base;
        i_rst_n = 0;
        i_in_valid = 0;
        i_symbol = 0;
        i_last = 0;
        i_out_ready = 0;
        tree_reset();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: first char creates length-1 node 2, start 0
        row = '{8'h00, 1'b0, 1, '{1'b1, 11'd1, 10'd2, 10'd0, 10'd1, 16'd0, ERR_NONE}};
        rows.push_back(row);
        row = '{8'h00, 1'b0, 1, '{1'b1, 11'd2, 10'd3, 10'd0, 10'd2, 16'd0, ERR_NONE}};
        rows.push_back(row);
        row = '{8'hFF, 1'b0, 0, '0}; rows.push_back(row);
        row = '{8'h00, 1'b0, 0, '0}; rows.push_back(row);
        row = '{8'h00, 1'b1, 0, '0}; rows.push_back(row);
        row = '{8'hAA, 1'b1, 0, '0}; rows.push_back(row);
        row = '{8'h55, 1'b1, 0, '0}; rows.push_back(row);
        row = '{8'h00, 1'b0, 0, '0}; rows.push_back(row);
        row = '{8'hFF, 1'b0, 0, '0}; rows.push_back(row);
        row = '{8'h00, 1'b0, 0, '0}; rows.push_back(row);
        row = '{8'hFF, 1'b0, 0, '0}; rows.push_back(row);
        row = '{8'h00, 1'b1, 0, '0}; rows.push_back(row);
        foreach (rows[k]) send_row(rows[k]);

        // text buffer full: 3-symbol cycle keeps the node count low
        for (int k = 0; k < MAX_LEN + 2; k++)
            send_char(SYM_W'(8'h7C + k % 3), k == MAX_LEN + 1, k < 8);

        base = chars_sent;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 21 : 0;
            if (phase == 1) begin
                fork
                    begin
                        recv_hold = 1;
                        repeat (300) @(negedge i_clk);
                        recv_hold = 0;
                    end
                    for (int k = 0; k < 12; k++) send_char(8'(k), k == 11, 0);
                join
                drain();
            end
            while (chars_sent - base < (phase + 1) * NUM_RANDOM / 3)
                send_random_string(chars_sent);
            drain();
        end

        // node table full: one long run of a single symbol
        send_idle_pct = 5;
        recv_idle_pct = 5;
        for (int k = 0; k < MAX_NODES; k++)
            send_char(8'h3C, k == MAX_NODES - 1, 1);
        for (int k = 0; k < 20; k++)
            send_char(SYM_W'($urandom_range(255)), k == 19, 1);

        drain();
        repeat (200) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
